// ===== hw/rtl/ipvhb_pkg.sv =====
// ipvhb_pkg: shared types and constants for the ipv4 header builder
// used by ipvhb_front, ipvhb_queue, ipvhb_back and ipv4_header_builder_unit
`timescale 1ns / 1ps

package ipvhb_pkg;

    // fixed header fields
    localparam logic [7:0]  VERSION_IHL  = 8'h45;
    localparam logic [15:0] HDR_BYTES    = 16'd20;
    localparam logic [15:0] DF_FLAG      = 16'h4000;

    // header word positions
    localparam logic [2:0]  WORD_LEN     = 3'd0;
    localparam logic [2:0]  WORD_IDENT   = 3'd1;
    localparam logic [2:0]  WORD_CSUM    = 3'd2;
    localparam logic [2:0]  WORD_SRC     = 3'd3;
    localparam logic [2:0]  WORD_DST     = 3'd4;

    // raw checksum sum width: ten 16-bit terms fit in 20 bits
    localparam int SUM_W = 20;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one classified request as it sits in the queue
    typedef struct packed {
        logic [7:0]       service_type;
        logic             dont_fragment;
        logic [7:0]       time_to_live;
        logic [7:0]       protocol_number;
        logic [31:0]      source_address;
        logic [31:0]      destination_address;
        logic [15:0]      total_length;
        logic [15:0]      ident;
        logic [SUM_W-1:0] sum;
    } t_hdr_entry;

endpackage

// ===== hw/rtl/ipvhb_front.sv =====
// ipvhb_front: accepts descriptors, assigns identification, forms checksum sum
// depends on ipvhb_pkg
`timescale 1ns / 1ps

module ipvhb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_service_type,
    input  logic                  i_dont_fragment,
    input  logic [7:0]            i_time_to_live,
    input  logic [7:0]            i_protocol_number,
    input  logic [31:0]           i_source_address,
    input  logic [31:0]           i_destination_address,
    input  logic [15:0]           i_payload_length,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output ipvhb_pkg::t_hdr_entry o_push_entry
);

    logic                  r_valid;
    logic [15:0]           r_ident;
    ipvhb_pkg::t_hdr_entry r_entry;
    logic [17:0]           r_p_addr;
    logic [17:0]           r_p_misc;
    logic                  w_accept;
    logic [15:0]           w_ident_next;
    logic [15:0]           w_total_length;

    // stage register frees when empty or when its request moves on
    assign o_in_ready = !r_valid || i_push_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // identification is pre-incremented and wraps
    assign w_ident_next   = r_ident + 16'd1;
    assign w_total_length = i_payload_length + ipvhb_pkg::HDR_BYTES;

    // control: stage valid and identification counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ident <= 16'd0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_ident <= w_ident_next;
            end else if (i_push_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload and partial sums of the header halfwords
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry.service_type        <= i_service_type;
            r_entry.dont_fragment       <= i_dont_fragment;
            r_entry.time_to_live        <= i_time_to_live;
            r_entry.protocol_number     <= i_protocol_number;
            r_entry.source_address      <= i_source_address;
            r_entry.destination_address <= i_destination_address;
            r_entry.total_length        <= w_total_length;
            r_entry.ident               <= w_ident_next;
            r_entry.sum                 <= '0;
            r_p_addr <= {2'b00, i_source_address[31:16]}
                      + {2'b00, i_source_address[15:0]}
                      + {2'b00, i_destination_address[31:16]}
                      + {2'b00, i_destination_address[15:0]};
            r_p_misc <= {2'b00, ipvhb_pkg::VERSION_IHL, i_service_type}
                      + {2'b00, w_total_length}
                      + {2'b00, i_time_to_live, i_protocol_number}
                      + {2'b00, (i_dont_fragment ? ipvhb_pkg::DF_FLAG : 16'd0)};
        end
    end

    // complete the raw sum with the identification on the way out
    always_comb begin
        o_push_entry     = r_entry;
        o_push_entry.sum = {2'b00, r_p_addr} + {2'b00, r_p_misc}
                         + {4'd0, r_entry.ident};
    end

    assign o_push_valid = r_valid;

endmodule

// ===== hw/rtl/ipvhb_queue.sv =====
// ipvhb_queue: small register queue of classified requests between front and back
// depends on ipvhb_pkg
`timescale 1ns / 1ps

module ipvhb_queue #(
    parameter int DEPTH = ipvhb_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    output logic                  o_push_ready,
    input  ipvhb_pkg::t_hdr_entry i_push_entry,
    output logic                  o_pop_valid,
    input  logic                  i_pop,
    output ipvhb_pkg::t_hdr_entry o_pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ipvhb_pkg::t_hdr_entry r_mem [DEPTH];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_entry  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hw/rtl/ipvhb_back.sv =====
// ipvhb_back: emits the five header words of each queued request, checksum folded here
// depends on ipvhb_pkg
`timescale 1ns / 1ps

module ipvhb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  ipvhb_pkg::t_hdr_entry i_head_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_header_word,
    output logic [2:0]            o_word_index,
    output logic                  o_last_word
);

    logic        r_valid;
    logic [2:0]  r_cnt;
    logic [31:0] r_word;
    logic [2:0]  r_idx;
    logic        r_last;
    logic        w_load;
    logic        w_take;
    logic [16:0] w_fold1;
    logic [16:0] w_fold2;
    logic [15:0] w_csum;
    logic [31:0] n_word;

    // output register reloads when empty or taken
    assign w_load = !r_valid || i_out_ready;
    assign w_take = w_load && i_head_valid;
    assign o_pop  = w_take && (r_cnt == ipvhb_pkg::WORD_DST);

    // end-around carry fold of the raw sum, then invert
    assign w_fold1 = {1'b0, i_head_entry.sum[15:0]}
                   + {13'd0, i_head_entry.sum[ipvhb_pkg::SUM_W-1:16]};
    assign w_fold2 = {1'b0, w_fold1[15:0]} + {16'd0, w_fold1[16]};
    assign w_csum  = ~w_fold2[15:0];

    // select the header word for the current position
    always_comb begin
        unique case (r_cnt)
            ipvhb_pkg::WORD_LEN: begin
                n_word = {ipvhb_pkg::VERSION_IHL, i_head_entry.service_type,
                          i_head_entry.total_length};
            end
            ipvhb_pkg::WORD_IDENT: begin
                n_word = {i_head_entry.ident,
                          (i_head_entry.dont_fragment ? ipvhb_pkg::DF_FLAG : 16'd0)};
            end
            ipvhb_pkg::WORD_CSUM: begin
                n_word = {i_head_entry.time_to_live, i_head_entry.protocol_number, w_csum};
            end
            ipvhb_pkg::WORD_SRC: begin
                n_word = i_head_entry.source_address;
            end
            ipvhb_pkg::WORD_DST: begin
                n_word = i_head_entry.destination_address;
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    // control: output valid and word position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= ipvhb_pkg::WORD_LEN;
        end else if (w_load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_cnt <= (r_cnt == ipvhb_pkg::WORD_DST) ? ipvhb_pkg::WORD_LEN
                                                        : r_cnt + 3'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word <= n_word;
            r_idx  <= r_cnt;
            r_last <= (r_cnt == ipvhb_pkg::WORD_DST);
        end
    end

    assign o_out_valid   = r_valid;
    assign o_header_word = r_word;
    assign o_word_index  = r_idx;
    assign o_last_word   = r_last;

`ifndef NO_ASSERTIONS
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_last == (r_idx == ipvhb_pkg::WORD_DST)))
        else $error("last flag off the final word");
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_ready && !r_last) |=> (r_valid && r_idx == $past(r_idx) + 3'd1))
        else $error("header word missing or out of order");
    a_new_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_ready && r_last) |=> (!r_valid || r_idx == ipvhb_pkg::WORD_LEN))
        else $error("header does not start at word zero");
`endif

endmodule

// ===== hw/rtl/ipv4_header_builder_unit.sv =====
// ipv4_header_builder_unit: a request passes the front stage register, the queue and the back output register
// throughput one header word per cycle while the output is ready, five words per request, set by the back output stage
// front stage accepts a new request each cycle while the queue has room
// synchronous active-low reset clears the queue, stage valids and identification to zero
// depends on ipvhb_pkg, ipvhb_front, ipvhb_queue, ipvhb_back
`timescale 1ns / 1ps

module ipv4_header_builder_unit #(
    parameter int QUEUE_DEPTH = ipvhb_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_service_type,
    input  logic        i_dont_fragment,
    input  logic [7:0]  i_time_to_live,
    input  logic [7:0]  i_protocol_number,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic [15:0] i_payload_length,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_header_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic                  w_push_valid;
    logic                  w_push_ready;
    ipvhb_pkg::t_hdr_entry w_push_entry;
    logic                  w_head_valid;
    logic                  w_pop;
    ipvhb_pkg::t_hdr_entry w_head_entry;

    // front: accept and classify
    ipvhb_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_service_type        (i_service_type),
        .i_dont_fragment       (i_dont_fragment),
        .i_time_to_live        (i_time_to_live),
        .i_protocol_number     (i_protocol_number),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_payload_length      (i_payload_length),
        .o_push_valid          (w_push_valid),
        .i_push_ready          (w_push_ready),
        .o_push_entry          (w_push_entry)
    );

    // queue between the two sides
    ipvhb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_entry (w_push_entry),
        .o_pop_valid  (w_head_valid),
        .i_pop        (w_pop),
        .o_pop_entry  (w_head_entry)
    );

    // back: word emission
    ipvhb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head_entry  (w_head_entry),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_header_word (o_header_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
